FILE: hdl/interval_coverage_summit_macros.svh
// Assertion helpers for the coverage histogram block
`ifndef INTERVAL_COVERAGE_SUMMIT_MACROS_SVH
`define INTERVAL_COVERAGE_SUMMIT_MACROS_SVH

// same-cycle implication
`define ICS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ICS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ics_pkg.sv
`default_nettype none

package ics_pkg;

  localparam int MaxPositions = 1024;
  localparam int CountWidth   = 16;
  localparam int CfgWidth     = 11;
  localparam int CfgReset     = 1024;
  localparam int TallyWidth   = 32;
  localparam int PosWidth     = 17;
  localparam int FuncWidth    = 2;

  typedef enum logic [FuncWidth-1:0] {
    FN_ADD = 2'd0,
    FN_QRY = 2'd1,
    FN_SUM = 2'd2,
    FN_CLR = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_WIPE,
    ST_IDLE,
    ST_DECODE,
    ST_RUN,
    ST_DRAIN,
    ST_ZERO,
    ST_FINISH
  } state_e;

  typedef enum logic [2:0] {
    SET_NONE,
    SET_ADD,
    SET_QRY,
    SET_SUM,
    SET_CLEAR
  } setup_e;

  typedef enum logic [1:0] {
    SCAN_NONE,
    SCAN_READ,
    SCAN_ZERO
  } scan_e;

  typedef struct packed {
    logic   load_item;
    setup_e setup;
    scan_e  scan;
    logic   tally_inc;
    logic   publish;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  miss;
    logic  empty;
    logic  oob;
    logic  scan_last;
    logic  out_free;
    logic  pipe_busy;
  } sts_t;

endpackage

`default_nettype wire

FILE: hdl/ics_req_if.sv
`default_nettype none

interface ics_req_if;
  logic                                valid;
  logic                                ready;
  logic [ics_pkg::FuncWidth-1:0]       func;
  logic signed [ics_pkg::PosWidth-1:0] left;
  logic signed [ics_pkg::PosWidth-1:0] right;
  logic signed [ics_pkg::PosWidth-1:0] index;

  modport source (output valid, func, left, right, index, input ready);
  modport sink   (input valid, func, left, right, index, output ready);
endinterface

`default_nettype wire

FILE: hdl/ics_res_if.sv
`default_nettype none

interface ics_res_if #(
  parameter int CW = ics_pkg::CountWidth,
  parameter int PW = $clog2(ics_pkg::MaxPositions)
);
  logic                             valid;
  logic                             ready;
  logic [CW-1:0]                    depth_value;
  logic [PW-1:0]                    peak_position;
  logic [CW-1:0]                    peak_height;
  logic [ics_pkg::TallyWidth-1:0]   interval_count;
  logic                             error;

  modport source (output valid, depth_value, peak_position, peak_height, interval_count,
                  error, input ready);
  modport sink   (input valid, depth_value, peak_position, peak_height, interval_count,
                  error, output ready);
endinterface

`default_nettype wire

FILE: hdl/ics_ram.sv
`default_nettype none

module ics_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire                      clk_i,
  input  wire                      wr_en_i,
  input  wire [$clog2(DEPTH)-1:0]  wr_addr_i,
  input  wire [WIDTH-1:0]          wr_data_i,
  input  wire                      rd_en_i,
  input  wire [$clog2(DEPTH)-1:0]  rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ics_ctrl.sv
`default_nettype none

module ics_ctrl (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           in_valid_i,
  output logic          in_ready_o,
  input  ics_pkg::sts_t sts_i,
  output ics_pkg::cmd_t cmd_o
);

  ics_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ics_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ics_pkg::ST_INIT: state_d = ics_pkg::ST_WIPE;
      ics_pkg::ST_WIPE: begin
        if (sts_i.scan_last) state_d = ics_pkg::ST_IDLE;
      end
      ics_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = ics_pkg::ST_DECODE;
      end
      ics_pkg::ST_DECODE: begin
        case (sts_i.func)
          ics_pkg::FN_ADD: begin
            state_d = (sts_i.miss || sts_i.empty) ? ics_pkg::ST_FINISH : ics_pkg::ST_RUN;
          end
          ics_pkg::FN_QRY: begin
            state_d = sts_i.oob ? ics_pkg::ST_FINISH : ics_pkg::ST_RUN;
          end
          ics_pkg::FN_SUM: state_d = ics_pkg::ST_RUN;
          default:         state_d = ics_pkg::ST_ZERO;
        endcase
      end
      ics_pkg::ST_RUN: begin
        if (sts_i.scan_last) state_d = ics_pkg::ST_DRAIN;
      end
      ics_pkg::ST_DRAIN: state_d = ics_pkg::ST_FINISH;
      ics_pkg::ST_ZERO: begin
        if (sts_i.scan_last) state_d = ics_pkg::ST_FINISH;
      end
      ics_pkg::ST_FINISH: begin
        if (sts_i.out_free) state_d = ics_pkg::ST_IDLE;
      end
      default: state_d = ics_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.setup     = ics_pkg::SET_NONE;
    cmd_o.scan      = ics_pkg::SCAN_NONE;
    in_ready_o      = 1'b0;
    case (state_q)
      ics_pkg::ST_INIT: cmd_o.setup = ics_pkg::SET_CLEAR;
      ics_pkg::ST_WIPE: cmd_o.scan  = ics_pkg::SCAN_ZERO;
      ics_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      ics_pkg::ST_DECODE: begin
        case (sts_i.func)
          ics_pkg::FN_ADD: begin
            cmd_o.tally_inc = !sts_i.miss;
            if (!sts_i.miss && !sts_i.empty) cmd_o.setup = ics_pkg::SET_ADD;
          end
          ics_pkg::FN_QRY: begin
            if (!sts_i.oob) cmd_o.setup = ics_pkg::SET_QRY;
          end
          ics_pkg::FN_SUM: cmd_o.setup = ics_pkg::SET_SUM;
          default:         cmd_o.setup = ics_pkg::SET_CLEAR;
        endcase
      end
      ics_pkg::ST_RUN:    cmd_o.scan    = ics_pkg::SCAN_READ;
      ics_pkg::ST_ZERO:   cmd_o.scan    = ics_pkg::SCAN_ZERO;
      ics_pkg::ST_FINISH: cmd_o.publish = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/ics_dp.sv
`default_nettype none

module ics_dp #(
  parameter int MAX_POSITIONS = ics_pkg::MaxPositions,
  parameter int COUNT_WIDTH   = ics_pkg::CountWidth
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire [ics_pkg::CfgWidth-1:0]         cfg_wdata_i,
  input  wire [ics_pkg::FuncWidth-1:0]        func_i,
  input  wire signed [ics_pkg::PosWidth-1:0]  left_i,
  input  wire signed [ics_pkg::PosWidth-1:0]  right_i,
  input  wire signed [ics_pkg::PosWidth-1:0]  index_i,
  input  wire                                 out_ready_i,
  output logic                                out_valid_o,
  output logic [COUNT_WIDTH-1:0]              depth_value_o,
  output logic [$clog2(MAX_POSITIONS)-1:0]    peak_position_o,
  output logic [COUNT_WIDTH-1:0]              peak_height_o,
  output logic [ics_pkg::TallyWidth-1:0]      interval_count_o,
  output logic                                error_o,
  input  ics_pkg::cmd_t                       cmd_i,
  output ics_pkg::sts_t                       sts_o
);

  localparam int AW   = $clog2(MAX_POSITIONS);
  localparam int PTRW = AW + 1;
  localparam int LENW = (PTRW > ics_pkg::CfgWidth) ? PTRW : ics_pkg::CfgWidth;
  localparam int CMPW = (PTRW + 1 > ics_pkg::PosWidth + 1) ? PTRW + 1 : ics_pkg::PosWidth + 1;
  localparam logic signed [CMPW-1:0] Zero = '0;

  logic [ics_pkg::CfgWidth-1:0]         wl_q;
  ics_pkg::func_e                       func_q;
  logic signed [ics_pkg::PosWidth-1:0]  left_q, right_q, index_q;
  logic [PTRW-1:0]                      ptr_q, end_q, ptr_nxt;
  logic                                 pv_q;
  logic [AW-1:0]                        pa_q;
  logic [COUNT_WIDTH-1:0]               best_q, depth_q;
  logic [AW-1:0]                        first_q, last_q;
  logic [ics_pkg::TallyWidth-1:0]       tally_q;

  logic [LENW-1:0]        wl_ext, len_w;
  logic [PTRW-1:0]        len, len_m1, idx_ptr;
  logic signed [CMPW-1:0] left_s, right_s, idx_s, len_s, lo_s, hi_s;
  logic                   miss, empty, oob;
  logic [COUNT_WIDTH-1:0] rd_data, count_inc;
  logic                   wr_en, rd_en;
  logic [AW-1:0]          wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic [AW:0]            mid_sum;

  // window length, clamped to the store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= ics_pkg::CfgWidth'(ics_pkg::CfgReset);
    end else if (cfg_we_i) begin
      wl_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    wl_ext = LENW'(wl_q);
    if (wl_ext == '0) begin
      len_w = LENW'(1);
    end else if (wl_ext > LENW'(MAX_POSITIONS)) begin
      len_w = LENW'(MAX_POSITIONS);
    end else begin
      len_w = wl_ext;
    end
  end

  assign len    = len_w[PTRW-1:0];
  assign len_m1 = len - PTRW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      func_q  <= ics_pkg::func_e'(func_i);
      left_q  <= left_i;
      right_q <= right_i;
      index_q <= index_i;
    end
  end

  assign left_s  = CMPW'(left_q);
  assign right_s = CMPW'(right_q);
  assign idx_s   = CMPW'(index_q);
  assign len_s   = $signed(CMPW'(len));
  assign miss    = (left_s >= len_s) || (right_s <= Zero);
  assign lo_s    = (left_s < Zero) ? Zero : left_s;
  assign hi_s    = (right_s > len_s) ? len_s : right_s;
  assign empty   = lo_s >= hi_s;
  assign oob     = (idx_s < Zero) || (idx_s >= len_s);
  assign idx_ptr = idx_s[PTRW-1:0];
  assign ptr_nxt = ptr_q + PTRW'(1);

  // scan pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      pv_q  <= 1'b0;
    end else begin
      pv_q <= (cmd_i.scan == ics_pkg::SCAN_READ);
      case (cmd_i.setup)
        ics_pkg::SET_ADD:   ptr_q <= lo_s[PTRW-1:0];
        ics_pkg::SET_QRY:   ptr_q <= idx_ptr;
        ics_pkg::SET_SUM:   ptr_q <= '0;
        ics_pkg::SET_CLEAR: ptr_q <= '0;
        default: begin
          if (cmd_i.scan != ics_pkg::SCAN_NONE) ptr_q <= ptr_nxt;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q <= ptr_q[AW-1:0];
    case (cmd_i.setup)
      ics_pkg::SET_ADD:   end_q <= hi_s[PTRW-1:0];
      ics_pkg::SET_QRY:   end_q <= idx_ptr + PTRW'(1);
      ics_pkg::SET_SUM:   end_q <= len;
      ics_pkg::SET_CLEAR: end_q <= PTRW'(MAX_POSITIONS);
      default: ;
    endcase
  end

  assign count_inc = (rd_data == '1) ? rd_data : rd_data + COUNT_WIDTH'(1);

  // summit tracking and query capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup == ics_pkg::SET_SUM) begin
      best_q  <= '0;
      first_q <= '0;
      last_q  <= '0;
    end else if (pv_q && func_q == ics_pkg::FN_SUM) begin
      if (rd_data > best_q) begin
        best_q  <= rd_data;
        first_q <= pa_q;
        last_q  <= pa_q;
      end else if (rd_data == best_q) begin
        last_q <= pa_q;
      end
    end
    if (pv_q && func_q == ics_pkg::FN_QRY) begin
      depth_q <= rd_data;
    end
  end

  assign rd_en   = (cmd_i.scan == ics_pkg::SCAN_READ);
  assign wr_en   = (cmd_i.scan == ics_pkg::SCAN_ZERO) || (pv_q && func_q == ics_pkg::FN_ADD);
  assign wr_addr = (cmd_i.scan == ics_pkg::SCAN_ZERO) ? ptr_q[AW-1:0] : pa_q;
  assign wr_data = (cmd_i.scan == ics_pkg::SCAN_ZERO) ? '0 : count_inc;

  ics_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (MAX_POSITIONS)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (ptr_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q <= '0;
    end else if (cmd_i.tally_inc && tally_q != '1) begin
      tally_q <= tally_q + ics_pkg::TallyWidth'(1);
    end
  end

  // all-zero window: midpoint of the whole window
  assign mid_sum = (best_q == '0) ? len_m1 : (PTRW'(first_q) + PTRW'(last_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      depth_value_o    <= (func_q == ics_pkg::FN_QRY && !oob) ? depth_q : '0;
      peak_position_o  <= (func_q == ics_pkg::FN_SUM) ? mid_sum[AW:1] : '0;
      peak_height_o    <= (func_q == ics_pkg::FN_SUM) ? best_q : '0;
      interval_count_o <= tally_q;
      error_o          <= (func_q == ics_pkg::FN_ADD && miss) ||
                          (func_q == ics_pkg::FN_QRY && oob);
    end
  end

  assign sts_o.func      = func_q;
  assign sts_o.miss      = miss;
  assign sts_o.empty     = empty;
  assign sts_o.oob       = oob;
  assign sts_o.scan_last = (ptr_nxt == end_q);
  assign sts_o.out_free  = !out_valid_o || out_ready_i;
  assign sts_o.pipe_busy = pv_q;

endmodule

`default_nettype wire

FILE: hdl/interval_coverage_summit.sv
// Each request is decoded, then the count RAM is scanned: add over the covered positions,
// query over its one position, summit over the window, clear over all MAX_POSITIONS.
// An add that misses the window or covers nothing, or an out-of-window query, skips the
// scan. One request at a time; the count RAM is scanned one position per cycle.
// Reset: a clearing pass zeroes the RAM, no request taken.
// Window length resets to 1024 and the interval tally to zero.
`default_nettype none

`include "interval_coverage_summit_macros.svh"

module interval_coverage_summit #(
  parameter int MAX_POSITIONS = ics_pkg::MaxPositions,
  parameter int COUNT_WIDTH   = ics_pkg::CountWidth
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire [ics_pkg::CfgWidth-1:0] cfg_wdata_i,
  ics_req_if.sink                     req_i,
  ics_res_if.source                   res_o
);

  ics_pkg::cmd_t cmd;
  ics_pkg::sts_t sts;
  logic          in_ready;

  assign req_i.ready = in_ready;

  ics_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ics_dp #(
    .MAX_POSITIONS (MAX_POSITIONS),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .func_i           (req_i.func),
    .left_i           (req_i.left),
    .right_i          (req_i.right),
    .index_i          (req_i.index),
    .out_ready_i      (res_o.ready),
    .out_valid_o      (res_o.valid),
    .depth_value_o    (res_o.depth_value),
    .peak_position_o  (res_o.peak_position),
    .peak_height_o    (res_o.peak_height),
    .interval_count_o (res_o.interval_count),
    .error_o          (res_o.error),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

  `ICS_ASSERT_IMPL(a_publish_free, cmd.publish, sts.out_free, "result loaded into a full output register")
  `ICS_ASSERT_IMPL(a_accept_quiet, req_i.valid && req_i.ready, !sts.pipe_busy && (cmd.scan == ics_pkg::SCAN_NONE), "request accepted during a scan")
  `ICS_ASSERT_NEXT(a_busy_after_load, cmd.load_item, !req_i.ready, "ready high right after a request")

endmodule

`default_nettype wire
